/* rtl/splc_pkg.sv */
// Shared types, codes and widths for the sorted priority/cost list.
package splc_pkg;

	localparam int KEY_W = 16;

	typedef logic signed [KEY_W-1:0] key_t;

	// Request opcodes
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DUMP   = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_DROPPED  = 2'd1;
	localparam logic [1:0] ST_DUMPED   = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic mode;
		key_t new_priority;
		key_t new_cost;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		key_t       out_priority;
		key_t       out_cost;
		logic       last;
	} out_t;

	// One stored entry
	typedef struct packed {
		key_t prio;
		key_t cost;
	} entry_t;

endpackage

/* rtl/splc_cmp.sv */
// Key comparator shared by every insert step: does the new entry sort after the stored one.
module splc_cmp import splc_pkg::*; (
	input  entry_t cur,
	input  entry_t fresh,
	output logic   goes_after
);

	// Ascending on priority, then cost; equal keys keep arrival order
	always_comb begin
		goes_after = (cur.prio < fresh.prio) ||
			((cur.prio == fresh.prio) && (cur.cost <= fresh.cost));
	end

endmodule

/* rtl/sorted_priority_cost_list_core.sv */
// Sorted priority/cost list core with a one-write, one-read entry memory and one shared comparator.
//
// Holds up to DEPTH entries in ascending order of priority, then cost (newer after older on
// equal keys). An insert request walks the list from the top down, one stored entry per
// cycle through the single comparator and the memory read register, shifting larger entries
// up one slot; an insert into an empty or full list is finished on acceptance (full gives a
// dropped result). A dump request emits every entry in order, each by a memory read and then
// an output register load, which waits while the output register holds an untaken result;
// a dump of an empty list gives one empty result. in_ready is low while a request is
// being worked on and while the output register holds an untaken result. The memory needs no
// clearing after reset: data read from slots at and above the entry count is never used.
module sorted_priority_cost_list_core import splc_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_INS_CMP  = 3'd1;
	localparam logic [2:0] S_INS_PUT  = 3'd2;
	localparam logic [2:0] S_DUMP_RD  = 3'd3;
	localparam logic [2:0] S_DUMP_OUT = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] count_q;
	entry_t        new_q;
	entry_t        rd_q;
	logic          out_valid_q;
	out_t          out_q;

	entry_t mem [DEPTH];

	logic          in_fire;
	logic          out_free;
	logic          out_load;
	logic          goes_after;
	logic          we;
	logic [CW-1:0] waddr;
	entry_t        wdata;
	logic [CW-1:0] raddr;
	entry_t        in_entry;

	assign in_entry.prio = in_data.new_priority;
	assign in_entry.cost = in_data.new_cost;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Output register gets a new result this cycle
	assign out_load = (in_fire && ((in_data.mode == MODE_DUMP) ? (count_q == '0) :
			((count_q == CW'(DEPTH)) || (count_q == '0)))) ||
		((state_q == S_INS_CMP) && goes_after) ||
		(state_q == S_INS_PUT) ||
		((state_q == S_DUMP_OUT) && out_free);

	// Shared compare unit: stored entry just read against the pending one
	splc_cmp u_cmp (
		.cur        (rd_q),
		.fresh      (new_q),
		.goes_after (goes_after)
	);

	// Memory port control
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rd_q;
		raddr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				raddr = count_q - CW'(1);
				waddr = '0;
				wdata = in_entry;
				we    = in_fire && (in_data.mode == MODE_INSERT) && (count_q == '0);
			end
			S_INS_CMP: begin
				raddr = idx_q - CW'(2);
				we    = 1'b1;
				wdata = goes_after ? new_q : rd_q;
			end
			S_INS_PUT: begin
				we    = 1'b1;
				wdata = new_q;
			end
			S_DUMP_RD, S_DUMP_OUT: begin
				raddr = idx_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Entry memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
		rd_q <= mem[raddr[AW-1:0]];
	end

	// Pending entry of an insert
	always_ff @(posedge clk) begin
		if (in_fire) begin
			new_q <= in_entry;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_data.mode == MODE_DUMP) begin
							if (count_q == '0) begin
								out_q <= '{ST_EMPTY, '0, '0, 1'b1};
							end else begin
								idx_q   <= '0;
								state_q <= S_DUMP_RD;
							end
						end else if (count_q == CW'(DEPTH)) begin
							out_q <= '{ST_DROPPED, '0, '0, 1'b1};
						end else if (count_q == '0) begin
							count_q <= count_q + CW'(1);
							out_q   <= '{ST_INSERTED, '0, '0, 1'b1};
						end else begin
							idx_q   <= count_q;
							state_q <= S_INS_CMP;
						end
					end
				end
				S_INS_CMP: begin
					if (goes_after) begin
						count_q <= count_q + CW'(1);
						out_q   <= '{ST_INSERTED, '0, '0, 1'b1};
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q - CW'(1);
						if (idx_q == CW'(1)) begin
							state_q <= S_INS_PUT;
						end
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + CW'(1);
					out_q   <= '{ST_INSERTED, '0, '0, 1'b1};
					state_q <= S_IDLE;
				end
				S_DUMP_RD: begin
					state_q <= S_DUMP_OUT;
				end
				S_DUMP_OUT: begin
					if (out_free) begin
						out_q <= '{ST_DUMPED, rd_q.prio, rd_q.cost,
							(idx_q == count_q - CW'(1))};
						if (idx_q == count_q - CW'(1)) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_DUMP_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_data.mode == MODE_INSERT) && (count_q == CW'(DEPTH)) |=>
		out_valid_q && (out_q.status == ST_DROPPED) && $stable(count_q))
		else $error("insert into full list not dropped");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && (out_q.status == ST_INSERTED) |->
		count_q == $past(count_q) + CW'(1))
		else $error("inserted result without count step");

	a_dump_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP_RD) || (state_q == S_DUMP_OUT) |-> !we && (idx_q < count_q))
		else $error("dump touched the list");

endmodule

/* tb/sorted_priority_cost_list_core_tb.sv */
// Self-checking testbench for the sorted priority/cost list core: directed table, then random requests.
module sorted_priority_cost_list_core_tb;
	import splc_pkg::*;

	localparam int LIST_DEPTH = 32;
	localparam int RANDOM_REQUESTS = 250;
	localparam int DRAIN_CYCLES = 100;

	// One row of the directed table; typed rows carry their expected status
	typedef struct packed {
		logic       mode;
		key_t       prio;
		key_t       cost;
		logic       typed;
		logic [1:0] status;
	} step_row_t;

	localparam int DIRECTED_ROWS = 19;
	localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{MODE_DUMP,   16'sh0000, 16'sh0000, 1'b1, ST_EMPTY},
		'{MODE_INSERT, 16'sh0000, 16'sh0000, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'sh7FFF, 16'sh7FFF, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'sh8000, 16'sh8000, 1'b1, ST_INSERTED},
		'{MODE_DUMP,   16'shFFFF, 16'shFFFF, 1'b0, ST_DUMPED},
		'{MODE_INSERT, 16'sh0000, 16'sh0000, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'sh0000, 16'shFFFF, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'sh0000, 16'sh0001, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'shFFFF, 16'sh7FFF, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'sh7FFF, 16'sh8000, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'sh8000, 16'sh7FFF, 1'b1, ST_INSERTED},
		'{MODE_DUMP,   16'sh5A5A, 16'shA5A5, 1'b0, ST_DUMPED},
		'{MODE_INSERT, 16'sh0001, 16'sh0000, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'shFFFF, 16'sh8000, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'sh5555, 16'shAAAA, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'shAAAA, 16'sh5555, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'sh0000, 16'sh0000, 1'b1, ST_INSERTED},
		'{MODE_INSERT, 16'sh8000, 16'sh8000, 1'b1, ST_INSERTED},
		'{MODE_DUMP,   16'sh0000, 16'sh0000, 1'b0, ST_DUMPED}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// Shadow copy of the sorted list
	key_t list_prio [LIST_DEPTH];
	key_t list_cost [LIST_DEPTH];
	int   list_len = 0;

	out_t pending_results [$];
	out_t head_result;
	int   mismatch_count = 0;
	bit   steady = 1'b0;

	sorted_priority_cost_list_core #(.DEPTH(LIST_DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Update the shadow list for one accepted request and queue the results it causes
	function automatic void predict_list_step(input in_t req);
		int slot;
		key_t p;
		key_t c;
		if (req.mode == MODE_DUMP) begin
			if (list_len == 0) begin
				pending_results.push_back('{ST_EMPTY, '0, '0, 1'b1});
			end else begin
				for (slot = 0; slot < list_len; slot++)
					pending_results.push_back('{ST_DUMPED, list_prio[slot], list_cost[slot],
						(slot == list_len - 1)});
			end
		end else if (list_len >= LIST_DEPTH) begin
			pending_results.push_back('{ST_DROPPED, '0, '0, 1'b1});
		end else begin
			// shift larger entries up; equal keys keep the newer one behind
			slot = list_len;
			while (slot > 0) begin
				p = list_prio[slot-1];
				c = list_cost[slot-1];
				if (p < req.new_priority || (p == req.new_priority && c <= req.new_cost))
					break;
				list_prio[slot] = p;
				list_cost[slot] = c;
				slot--;
			end
			list_prio[slot] = req.new_priority;
			list_cost[slot] = req.new_cost;
			list_len++;
			pending_results.push_back('{ST_INSERTED, '0, '0, 1'b1});
		end
	endfunction

	// Mix of full-range keys, near-zero keys for ties, and the extremes
	function automatic key_t rand_key();
		case ($urandom_range(9))
			0, 1, 2, 3: return key_t'($urandom);
			4, 5, 6:    return key_t'(int'($urandom_range(6)) - 3);
			7:          return 16'sh7FFF;
			8:          return 16'sh8000;
			default:    return key_t'(-int'($urandom_range(1)));
		endcase
	endfunction

	// Offer one request, with random idle gaps ahead of it, and predict on acceptance
	task automatic send_request(input in_t req, input logic typed, input logic [1:0] status);
		while (!steady && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (!in_ready);
		predict_list_step(req);
		// typed rows are checked against the value written in the table
		if (typed)
			pending_results[pending_results.size()-1] = '{status, '0, '0, 1'b1};
	endtask

	// Result check and output backpressure
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: status=%0d prio=%0d cost=%0d last=%0d",
					$time, out_data.status, out_data.out_priority, out_data.out_cost,
					out_data.last);
				mismatch_count++;
			end else begin
				head_result = pending_results.pop_front();
				if (out_data !== head_result) begin
					$write("%0t: mismatch: expected status=%0d prio=%0d cost=%0d last=%0d, ",
						$time, head_result.status, head_result.out_priority,
						head_result.out_cost, head_result.last);
					$display("got status=%0d prio=%0d cost=%0d last=%0d",
						out_data.status, out_data.out_priority, out_data.out_cost,
						out_data.last);
					mismatch_count++;
				end
			end
		end
		out_ready <= steady || ($urandom_range(99) >= 34);
	end

	// Stimulus
	initial begin
		int n;
		in_t req;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (n = 0; n < DIRECTED_ROWS; n++) begin
			req.mode         = DIRECTED[n].mode;
			req.new_priority = DIRECTED[n].prio;
			req.new_cost     = DIRECTED[n].cost;
			send_request(req, DIRECTED[n].typed, DIRECTED[n].status);
		end

		// random part: fill the list with occasional dumps, then drops and full dumps
		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			steady = (n >= 90 && n < 150);
			if (list_len < LIST_DEPTH)
				req.mode = ($urandom_range(99) < 12) ? MODE_DUMP : MODE_INSERT;
			else
				req.mode = ($urandom_range(99) < 20) ? MODE_DUMP : MODE_INSERT;
			req.new_priority = rand_key();
			req.new_cost     = rand_key();
			send_request(req, 1'b0, ST_INSERTED);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
rtl/splc_pkg.sv
rtl/splc_cmp.sv
rtl/sorted_priority_cost_list_core.sv
tb/sorted_priority_cost_list_core_tb.sv
